// File: rtl/core/tgarle_pkg.sv
package tgarle_pkg;

   localparam int unsigned CsrAddrWidth = 4;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DEPTH_IS_32  = 2'd2;
   localparam logic [1:0] REG_RLE_MODE     = 2'd3;

   localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
   localparam logic [7:0] RUN_BIAS       = 8'd127;

   typedef struct packed {
      logic        depth_is_32;
      logic        rle_mode;
      logic [31:0] pixel_total;
   } tgarle_cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       image_done;
      logic       overflow_error;
   } tgarle_result_type;

endpackage

// File: rtl/core/tgarle_core.sv
module tgarle_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_accept,
   input  logic [7:0]                   data_byte,
   input  logic                         frame_start,
   input  tgarle_pkg::tgarle_cfg_type   cfg,
   output logic                         result_valid,
   output tgarle_pkg::tgarle_result_type result
);

   logic        expect_header_ff, expect_header_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        run_packet_ff, run_packet_in;
   logic [1:0]  byte_position_ff, byte_position_in;
   logic [31:0] pixels_done_ff, pixels_done_in;
   logic        stopped_ff, stopped_in;
   logic [7:0]  color_ff [3];
   logic        color_we;
   logic        header_cycle;

   always_comb begin
      logic        eh;
      logic [7:0]  pl;
      logic        rp;
      logic [1:0]  bp;
      logic [31:0] pd;
      logic        st;
      logic [1:0]  last_pos;
      logic [7:0]  pix [4];
      logic [7:0]  count;
      logic [32:0] after;

      eh = frame_start ? cfg.rle_mode : expect_header_ff;
      pl = frame_start ? 8'd0 : packet_left_ff;
      rp = frame_start ? 1'b0 : run_packet_ff;
      bp = frame_start ? 2'd0 : byte_position_ff;
      pd = frame_start ? 32'd0 : pixels_done_ff;
      st = frame_start ? 1'b0 : stopped_ff;

      expect_header_in = eh;
      packet_left_in   = pl;
      run_packet_in    = rp;
      byte_position_in = bp;
      pixels_done_in   = pd;
      stopped_in       = st;
      color_we         = 1'b0;
      header_cycle     = 1'b0;
      result_valid     = 1'b0;
      result           = '0;
      last_pos         = cfg.depth_is_32 ? 2'd3 : 2'd2;
      pix[0]           = color_ff[0];
      pix[1]           = color_ff[1];
      pix[2]           = color_ff[2];
      pix[3]           = 8'd0;
      count            = 8'd1;
      after            = '0;

      if (!st) begin
         if (cfg.rle_mode && (eh || pl == 8'd0)) begin
            header_cycle = 1'b1;
            if (data_byte < tgarle_pkg::RUN_HEADER_MIN) begin
               run_packet_in  = 1'b0;
               packet_left_in = data_byte + 8'd1;
            end else begin
               run_packet_in  = 1'b1;
               packet_left_in = data_byte - tgarle_pkg::RUN_BIAS;
            end
            expect_header_in = 1'b0;
            byte_position_in = 2'd0;
         end else if (bp < last_pos) begin
            color_we         = 1'b1;
            byte_position_in = bp + 2'd1;
         end else begin
            pix[bp]          = data_byte;
            byte_position_in = 2'd0;
            if (cfg.rle_mode && rp) begin
               count          = pl;
               packet_left_in = 8'd0;
            end else if (cfg.rle_mode) begin
               packet_left_in = pl - 8'd1;
            end
            if (cfg.rle_mode && packet_left_in == 8'd0) begin
               expect_header_in = 1'b1;
            end
            after = {1'b0, pd} + {25'd0, count};
            if (after > {1'b0, cfg.pixel_total}) begin
               result.overflow_error = 1'b1;
               stopped_in            = 1'b1;
            end else begin
               pixels_done_in = after[31:0];
               if (after[31:0] == cfg.pixel_total &&
                   (!cfg.rle_mode || packet_left_in == 8'd0)) begin
                  result.image_done = 1'b1;
                  stopped_in        = 1'b1;
               end
            end
            result_valid        = 1'b1;
            result.red          = pix[2];
            result.green        = pix[1];
            result.blue         = pix[0];
            result.alpha        = cfg.depth_is_32 ? pix[3] : 8'd0;
            result.repeat_count = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         packet_left_ff   <= 8'd0;
         run_packet_ff    <= 1'b0;
         byte_position_ff <= 2'd0;
         pixels_done_ff   <= 32'd0;
         stopped_ff       <= 1'b0;
      end else if (in_accept) begin
         expect_header_ff <= expect_header_in;
         packet_left_ff   <= packet_left_in;
         run_packet_ff    <= run_packet_in;
         byte_position_ff <= byte_position_in;
         pixels_done_ff   <= pixels_done_in;
         stopped_ff       <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept && color_we) begin
         color_ff[byte_position_in - 2'd1] <= data_byte;
      end
   end

   // a word that ends the image or overflows must stop decoding
   a_stop_after_end: assert property (@(posedge clock) disable iff (reset)
      in_accept && result_valid && (result.image_done || result.overflow_error)
      |=> stopped_ff)
      else $error("decoder did not stop after end of image");

   a_header_no_word: assert property (@(posedge clock) disable iff (reset)
      in_accept && header_cycle |-> !result_valid)
      else $error("packet header produced a word");

endmodule

// File: rtl/core/tga_rle_pixel_decoder.sv
// Targa pixel-data decoder. Software parses the file header and writes image_width,
// image_height, depth_is_32 and rle_mode over the csr port, then streams the pixel-data
// bytes in, one per word, raising req_frame_start on the first byte of each frame.
// One byte is taken every clock cycle while req_stall is low; each completed pixel
// (or run) leaves as one registered rsp word carrying red, green, blue, alpha and its
// repeat count. A two-word output buffer sits in front of rsp, so req_stall rises only
// when both entries hold words that the receiver has not taken. After image_done or
// overflow_error the decoder drops bytes until the next frame start. The pixel total is
// the registered product of width and height, updated at the same edge as the register.
module tga_rle_pixel_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_frame_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_red,
   output logic [7:0]                            rsp_green,
   output logic [7:0]                            rsp_blue,
   output logic [7:0]                            rsp_alpha,
   output logic [7:0]                            rsp_repeat_count,
   output logic                                  rsp_image_done,
   output logic                                  rsp_overflow_error,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tgarle_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   logic [15:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic        depth_is_32_ff;
   logic        rle_mode_ff;
   logic [31:0] pixel_total_ff, pixel_total_in;
   logic [15:0] width_in, height_in;
   logic        csr_write;
   logic [1:0]  csr_index;

   logic                          in_accept;
   logic                          core_valid;
   tgarle_pkg::tgarle_result_type core_result;
   tgarle_pkg::tgarle_cfg_type    cfg;

   logic                          out_valid_ff, out_valid_in;
   tgarle_pkg::tgarle_result_type out_ff, out_in;
   logic                          skid_valid_ff, skid_valid_in;
   tgarle_pkg::tgarle_result_type skid_ff;
   logic                          out_take;
   logic                          new_word;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         tgarle_pkg::REG_IMAGE_WIDTH:  csr_prdata = {16'd0, image_width_ff};
         tgarle_pkg::REG_IMAGE_HEIGHT: csr_prdata = {16'd0, image_height_ff};
         tgarle_pkg::REG_DEPTH_IS_32:  csr_prdata = {31'd0, depth_is_32_ff};
         tgarle_pkg::REG_RLE_MODE:     csr_prdata = {31'd0, rle_mode_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   assign width_in  = (csr_write && csr_index == tgarle_pkg::REG_IMAGE_WIDTH) ?
                      csr_pwdata[15:0] : image_width_ff;
   assign height_in = (csr_write && csr_index == tgarle_pkg::REG_IMAGE_HEIGHT) ?
                      csr_pwdata[15:0] : image_height_ff;
   assign pixel_total_in = width_in * height_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 16'd1;
         image_height_ff <= 16'd1;
         depth_is_32_ff  <= 1'b0;
         rle_mode_ff     <= 1'b1;
         pixel_total_ff  <= 32'd1;
      end else begin
         image_width_ff  <= width_in;
         image_height_ff <= height_in;
         pixel_total_ff  <= pixel_total_in;
         if (csr_write && csr_index == tgarle_pkg::REG_DEPTH_IS_32) begin
            depth_is_32_ff <= csr_pwdata[0];
         end
         if (csr_write && csr_index == tgarle_pkg::REG_RLE_MODE) begin
            rle_mode_ff <= csr_pwdata[0];
         end
      end
   end

   assign cfg.depth_is_32 = depth_is_32_ff;
   assign cfg.rle_mode    = rle_mode_ff;
   assign cfg.pixel_total = pixel_total_ff;

   assign req_stall = skid_valid_ff;
   assign in_accept = req_valid && !skid_valid_ff;

   tgarle_core u_core (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .data_byte    (req_data_byte),
      .frame_start  (req_frame_start),
      .cfg          (cfg),
      .result_valid (core_valid),
      .result       (core_result)
   );

   assign new_word = in_accept && core_valid;
   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_take) begin
         skid_valid_in = 1'b0;
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = skid_ff;
         end else begin
            out_valid_in = new_word;
            out_in       = core_result;
         end
      end else if (new_word) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (new_word && out_valid_ff && !out_take) begin
         skid_ff <= core_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_red            = out_ff.red;
   assign rsp_green          = out_ff.green;
   assign rsp_blue           = out_ff.blue;
   assign rsp_alpha          = out_ff.alpha;
   assign rsp_repeat_count   = out_ff.repeat_count;
   assign rsp_image_done     = out_ff.image_done;
   assign rsp_overflow_error = out_ff.overflow_error;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_done_xor_err: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.image_done && out_ff.overflow_error))
      else $error("word flags both done and overflow");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.repeat_count != 8'd0)
      else $error("word with zero repeat count");

endmodule

// File: tb/sv/tga_rle_checker.sv
`timescale 1ns / 1ps

module tga_rle_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_frame_start,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [7:0]                          rsp_red,
   input  logic [7:0]                          rsp_green,
   input  logic [7:0]                          rsp_blue,
   input  logic [7:0]                          rsp_alpha,
   input  logic [7:0]                          rsp_repeat_count,
   input  logic                                rsp_image_done,
   input  logic                                rsp_overflow_error,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [tgarle_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output int                                  pending,
   output int                                  fail_count,
   output int                                  words_checked,
   output int                                  done_seen,
   output int                                  overflow_seen
);

   tgarle_pkg::tgarle_result_type pixel_q[$];

   logic [15:0] img_width;
   logic [15:0] img_height;
   logic        depth32;
   logic        rle_on;

   logic        hdr_due;
   logic [7:0]  pkt_left;
   logic        run_pkt;
   logic [1:0]  byte_pos;
   logic [7:0]  color_store [3];
   logic [31:0] px_done;
   logic        halted;

   int bad_count;
   int checked;
   int dones;
   int overflows;

   task automatic decode_byte(input logic [7:0] b, input logic fs);
      logic [1:0]       last_pos;
      logic [7:0]       cnt;
      logic [3:0][7:0]  pix;
      logic [31:0]      total;
      logic [32:0]      after;
      tgarle_pkg::tgarle_result_type r;
      if (fs) begin
         hdr_due  = rle_on;
         pkt_left = 8'd0;
         run_pkt  = 1'b0;
         byte_pos = 2'd0;
         px_done  = 32'd0;
         halted   = 1'b0;
      end
      if (halted)
         return;
      if (rle_on && (hdr_due || pkt_left == 8'd0)) begin
         if (b < tgarle_pkg::RUN_HEADER_MIN) begin
            run_pkt  = 1'b0;
            pkt_left = b + 8'd1;
         end else begin
            run_pkt  = 1'b1;
            pkt_left = b - tgarle_pkg::RUN_BIAS;
         end
         hdr_due  = 1'b0;
         byte_pos = 2'd0;
         return;
      end
      last_pos = depth32 ? 2'd3 : 2'd2;
      if (byte_pos < last_pos) begin
         color_store[byte_pos] = b;
         byte_pos = byte_pos + 2'd1;
         return;
      end
      pix[0] = color_store[0];
      pix[1] = color_store[1];
      pix[2] = color_store[2];
      pix[3] = 8'd0;
      pix[byte_pos] = b;
      byte_pos = 2'd0;
      if (rle_on && run_pkt) begin
         cnt      = pkt_left;
         pkt_left = 8'd0;
      end else begin
         cnt = 8'd1;
         if (rle_on)
            pkt_left = pkt_left - 8'd1;
      end
      if (rle_on && pkt_left == 8'd0)
         hdr_due = 1'b1;
      total = img_width * img_height;
      after = px_done + cnt;
      r.image_done     = 1'b0;
      r.overflow_error = 1'b0;
      if (after > {1'b0, total}) begin
         r.overflow_error = 1'b1;
         halted = 1'b1;
      end else begin
         px_done = after[31:0];
         if (after == {1'b0, total} && (!rle_on || pkt_left == 8'd0)) begin
            r.image_done = 1'b1;
            halted = 1'b1;
         end
      end
      r.red          = pix[2];
      r.green        = pix[1];
      r.blue         = pix[0];
      r.alpha        = depth32 ? pix[3] : 8'd0;
      r.repeat_count = cnt;
      pixel_q.push_back(r);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         bad_count++;
      end
   endtask

   task automatic check_word();
      tgarle_pkg::tgarle_result_type want;
      if (pixel_q.size() == 0) begin
         $display("%0t: unexpected word, expected none actual r%0d g%0d b%0d a%0d n%0d",
                  $time, rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_count);
         bad_count++;
         return;
      end
      want = pixel_q.pop_front();
      checked++;
      if (rsp_image_done) dones++;
      if (rsp_overflow_error) overflows++;
      compare_field("red", want.red, rsp_red);
      compare_field("green", want.green, rsp_green);
      compare_field("blue", want.blue, rsp_blue);
      compare_field("alpha", want.alpha, rsp_alpha);
      compare_field("repeat_count", want.repeat_count, rsp_repeat_count);
      compare_field("image_done", want.image_done, rsp_image_done);
      compare_field("overflow_error", want.overflow_error, rsp_overflow_error);
   endtask

   initial begin
      bad_count = 0;
      checked   = 0;
      dones     = 0;
      overflows = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         img_width      = 16'd1;
         img_height     = 16'd1;
         depth32        = 1'b0;
         rle_on         = 1'b1;
         hdr_due        = 1'b1;
         pkt_left       = 8'd0;
         run_pkt        = 1'b0;
         byte_pos       = 2'd0;
         color_store[0] = 8'd0;
         color_store[1] = 8'd0;
         color_store[2] = 8'd0;
         px_done        = 32'd0;
         halted         = 1'b0;
         pixel_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               tgarle_pkg::REG_IMAGE_WIDTH:  img_width  = csr_pwdata[15:0];
               tgarle_pkg::REG_IMAGE_HEIGHT: img_height = csr_pwdata[15:0];
               tgarle_pkg::REG_DEPTH_IS_32:  depth32    = csr_pwdata[0];
               tgarle_pkg::REG_RLE_MODE:     rle_on     = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            decode_byte(req_data_byte, req_frame_start);
         if (rsp_valid && !rsp_stall)
            check_word();
      end
      pending       <= pixel_q.size();
      fail_count    <= bad_count;
      words_checked <= checked;
      done_seen     <= dones;
      overflow_seen <= overflows;
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_count;
   logic        rsp_image_done;
   logic        rsp_overflow_error;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [tgarle_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int pending;
   int fail_count;
   int words_checked;
   int done_seen;
   int overflow_seen;

   bit          calm = 1'b0;
   bit          fs_next = 1'b0;
   int          words_sent = 0;
   int          settings_used = 0;
   logic [15:0] cur_w = 16'd1;
   logic [15:0] cur_h = 16'd1;
   logic        cur_depth32 = 1'b0;
   logic        cur_rle = 1'b1;

   tga_rle_pixel_decoder DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_alpha          (rsp_alpha),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_image_done     (rsp_image_done),
      .rsp_overflow_error (rsp_overflow_error),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   tga_rle_checker pixel_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_alpha          (rsp_alpha),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_image_done     (rsp_image_done),
      .rsp_overflow_error (rsp_overflow_error),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_pready         (csr_pready),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .pending            (pending),
      .fail_count         (fail_count),
      .words_checked      (words_checked),
      .done_seen          (done_seen),
      .overflow_seen      (overflow_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 34);
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] w, input logic [15:0] h,
                             input logic d32, input logic rle);
      csr_write(tgarle_pkg::REG_IMAGE_WIDTH, {16'd0, w});
      csr_write(tgarle_pkg::REG_IMAGE_HEIGHT, {16'd0, h});
      csr_write(tgarle_pkg::REG_DEPTH_IS_32, {31'd0, d32});
      csr_write(tgarle_pkg::REG_RLE_MODE, {31'd0, rle});
      cur_w       = w;
      cur_h       = h;
      cur_depth32 = d32;
      cur_rle     = rle;
      settings_used++;
   endtask

   // drain outstanding pixel words, then give the pipeline time to go quiet
   task automatic settle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending != 0 && guard < 20000);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_word(input logic [7:0] b);
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_frame_start <= fs_next;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fs_next = 1'b0;
      words_sent++;
      if (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_pixel();
      repeat (cur_depth32 ? 4 : 3) send_word(8'($urandom_range(255)));
   endtask

   task automatic play_frame(input bit allow_over);
      longint unsigned total;
      longint unsigned placed;
      longint unsigned room;
      int unsigned     n;
      int              budget;
      total  = cur_w * cur_h;
      placed = 0;
      budget = words_sent + 80;
      while (placed < total && words_sent < budget) begin
         room = total - placed;
         if (!cur_rle) begin
            send_pixel();
            placed++;
         end else if ($urandom_range(1)) begin
            n = $urandom_range(1, 8);
            if (!allow_over && n > room) n = 32'(room);
            send_word(8'(n - 1));
            repeat (n) send_pixel();
            placed += n;
         end else begin
            n = ($urandom_range(3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            if (!allow_over && n > room) n = 32'(room);
            send_word(8'(n + 127));
            send_pixel();
            placed += n;
         end
      end
   endtask

   function automatic logic [15:0] pick_dim();
      case ($urandom_range(9))
         0: return 16'hFFFF;
         1: return 16'($urandom_range(1, 65535));
         2: return 16'd1;
         default: return 16'($urandom_range(2, 6));
      endcase
   endfunction

   initial begin
      int k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // raw packet of one, then a run that completes the image, then a dropped byte
      set_config(16'd3, 16'd1, 1'b0, 1'b1);
      fs_next = 1'b1;
      send_word(8'h00);
      send_word(8'h00);
      send_word(8'hFF);
      send_word(8'h80);
      send_word(8'h81);
      send_word(8'hFF);
      send_word(8'h00);
      send_word(8'h7F);
      send_word(8'hFF);
      settle();

      // longest run overflows; then total reached inside a raw packet of 128
      set_config(16'd1, 16'd1, 1'b1, 1'b1);
      fs_next = 1'b1;
      send_word(8'hFF);
      k = 0;
      repeat (4) begin
         send_word(8'(k * 61 + 3));
         k++;
      end
      fs_next = 1'b1;
      send_word(8'h7F);
      send_pixel();
      send_pixel();
      settle();

      // zero height, plain mode: first pixel overflows
      set_config(16'hFFFF, 16'd0, 1'b0, 1'b0);
      fs_next = 1'b1;
      send_pixel();
      settle();

      // depth drops to 24 with the fourth byte still to come
      set_config(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      fs_next = 1'b1;
      repeat (3) send_word(8'($urandom_range(255)));
      settle();
      csr_write(tgarle_pkg::REG_DEPTH_IS_32, 32'd0);
      cur_depth32 = 1'b0;
      send_word(8'hA5);
      send_pixel();

      while (words_sent < 920) begin
         calm = (words_sent >= 350 && words_sent < 520);
         settle();
         set_config(pick_dim(), pick_dim(), 1'($urandom_range(1)), 1'($urandom_range(1)));
         fs_next = ($urandom_range(99) < 85);
         if ($urandom_range(4) != 0) begin
            play_frame($urandom_range(3) == 0);
         end else begin
            repeat ($urandom_range(5, 20)) begin
               send_word(8'($urandom_range(255)));
               fs_next = ($urandom_range(19) == 0);
            end
            fs_next = 1'b0;
         end
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) send_word(8'($urandom_range(255)));
      end

      calm = 1'b0;
      settle();
      $display("Sent %0d data bytes under %0d register settings; checked %0d pixel words",
               words_sent, settings_used, words_checked);
      $display("(%0d image completions, %0d overflows)", done_seen, overflow_seen);
      if (pending != 0)
         $display("%0t: %0d expected pixel words never arrived", $time, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("** tga_rle_pixel_decoder: PASSED **");
      end else begin
         $display("** tga_rle_pixel_decoder: FAILED **");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("%0t: timeout", $time);
      $display("** tga_rle_pixel_decoder: FAILED **");
      $finish;
   end

endmodule
